FILE: design/ulrr_pkg.sv
// Shared constants, types and helpers for the line-buffered receive ring.
package ulrr_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // Field widths of the streaming channels.
  localparam int BYTE_W      = 8;
  localparam int LINES_W     = 11;
  localparam int OUT_TDATA_W = 24;

  // The byte that terminates a line.
  localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;

  // Request kinds carried on the input tuser.
  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } ctrl_state_t;

  // Access request from the controller to the ring memory.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ring_req_t;

  // Advance a ring index, wrapping after the last slot.
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] res;
    if (idx == ADDR_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + ADDR_W'(1);
    end
    return res;
  endfunction

endpackage

FILE: design/ulrr_store.sv
// Byte storage of the receive ring: one write port and one registered read port.
module ulrr_store (
  input  logic                         clk,
  input  ulrr_pkg::ring_req_t          req,
  output logic [ulrr_pkg::BYTE_W-1:0]  rd_data
);

  logic [ulrr_pkg::BYTE_W-1:0] mem [ulrr_pkg::RING_DEPTH];
  logic [ulrr_pkg::BYTE_W-1:0] rd_data_r;

  // Write port. Entries hold no reset value; only written slots are ever read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/uart_line_receive_ring.sv
// Top level of the line-buffered serial receive ring.
//
// Usage: the input channel carries one transaction per request. in_tuser selects
// the kind: low stores the received byte in in_tdata into the ring, high pops one
// byte of the oldest complete line. Every input transaction produces exactly one
// output transaction with the popped byte (if any), the end-of-line mark on
// out_tlast, the count of complete lines still stored, the in-progress flag and
// the overrun flag for a byte dropped on a full ring.
// An arrival, or a pop with no complete line stored, is answered on the cycle after
// acceptance. A reading pop first passes through the read state, because the ring
// memory registers its read data. Arrivals are taken one per cycle while out_tready
// keeps up; no request is accepted while a reading pop is in the read state.
// The output register lets a new transaction be accepted in the cycle its previous
// result is taken; while out_tready stays low with a result waiting, in_tready is
// low and nothing is lost.
// Reset clears the indices, fill level, line count, in-progress flag and out_tvalid
// at once; the memory contents are not cleared and no clearing pass is needed.
module uart_line_receive_ring (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  input  logic                              in_tuser,   // [0] req_type
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ulrr_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] data_byte,
                                                        // [18:8] lines_waiting,
                                                        // [19] line_in_progress,
                                                        // [20] overrun, [23:21] zero
  output logic                              out_tuser,  // [0] data_valid
  output logic                              out_tlast   // end_of_line
);

  // Ring control state.
  ulrr_pkg::ctrl_state_t                 state_r, state_nxt;
  logic [ulrr_pkg::ADDR_W-1:0]           wr_idx_r, wr_idx_nxt;
  logic [ulrr_pkg::ADDR_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic [ulrr_pkg::FILL_W-1:0]           fill_r, fill_nxt;
  logic [ulrr_pkg::FILL_W-1:0]           lines_r, lines_nxt;
  logic                                  partial_r, partial_nxt;

  // Output register.
  logic                                  out_valid_r, out_valid_nxt;
  logic [ulrr_pkg::BYTE_W-1:0]           out_byte_r, out_byte_nxt;
  logic                                  out_dv_r, out_dv_nxt;
  logic                                  out_eol_r, out_eol_nxt;
  logic [ulrr_pkg::LINES_W-1:0]          out_lines_r, out_lines_nxt;
  logic                                  out_lip_r, out_lip_nxt;
  logic                                  out_ovr_r, out_ovr_nxt;

  ulrr_pkg::ring_req_t                   ring_req;
  logic [ulrr_pkg::BYTE_W-1:0]           rd_data;
  logic                                  in_acc;
  logic                                  ring_full;
  logic                                  line_ready;

  ulrr_store u_store (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  // Accept only when idle and the output register is free or being emptied.
  assign in_tready  = (state_r == ulrr_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign ring_full  = (fill_r == ulrr_pkg::FILL_W'(ulrr_pkg::RING_DEPTH));
  assign line_ready = (lines_r != '0) && (fill_r != '0);

  // Next-state logic for the ring and the output register.
  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    fill_nxt      = fill_r;
    lines_nxt     = lines_r;
    partial_nxt   = partial_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_dv_nxt    = out_dv_r;
    out_eol_nxt   = out_eol_r;
    out_lines_nxt = out_lines_r;
    out_lip_nxt   = out_lip_r;
    out_ovr_nxt   = out_ovr_r;
    ring_req      = '0;
    ring_req.wr_addr = wr_idx_r;
    ring_req.wr_data = in_tdata;
    ring_req.rd_addr = rd_idx_r;

    unique case (state_r)
      ulrr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ulrr_pkg::REQ_ARRIVE) begin
            // Store the byte unless the ring is full.
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_dv_nxt    = 1'b0;
            out_eol_nxt   = 1'b0;
            out_ovr_nxt   = ring_full;
            if (!ring_full) begin
              ring_req.wr_en = 1'b1;
              wr_idx_nxt     = ulrr_pkg::next_slot(wr_idx_r);
              fill_nxt       = fill_r + ulrr_pkg::FILL_W'(1);
              partial_nxt    = 1'b1;
              if (in_tdata == ulrr_pkg::LINE_FEED) begin
                lines_nxt   = lines_r + ulrr_pkg::FILL_W'(1);
                partial_nxt = 1'b0;
              end
            end
            out_lines_nxt = ulrr_pkg::LINES_W'(lines_nxt);
            out_lip_nxt   = partial_nxt;
          end else if (line_ready) begin
            // Fetch the oldest byte; the result follows once data returns.
            ring_req.rd_en = 1'b1;
            state_nxt      = ulrr_pkg::ST_READ;
          end else begin
            // No complete line stored: answer with an empty pop.
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_dv_nxt    = 1'b0;
            out_eol_nxt   = 1'b0;
            out_ovr_nxt   = 1'b0;
            out_lines_nxt = ulrr_pkg::LINES_W'(lines_r);
            out_lip_nxt   = partial_r;
          end
        end
      end
      ulrr_pkg::ST_READ: begin
        // Read data is back: retire the byte and update the line count.
        rd_idx_nxt    = ulrr_pkg::next_slot(rd_idx_r);
        fill_nxt      = fill_r - ulrr_pkg::FILL_W'(1);
        out_eol_nxt   = (rd_data == ulrr_pkg::LINE_FEED);
        if (rd_data == ulrr_pkg::LINE_FEED) begin
          lines_nxt = lines_r - ulrr_pkg::FILL_W'(1);
        end
        out_valid_nxt = 1'b1;
        out_byte_nxt  = rd_data;
        out_dv_nxt    = 1'b1;
        out_ovr_nxt   = 1'b0;
        out_lines_nxt = ulrr_pkg::LINES_W'(lines_nxt);
        out_lip_nxt   = partial_r;
        state_nxt     = ulrr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ulrr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ulrr_pkg::ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      lines_r     <= '0;
      partial_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      fill_r      <= fill_nxt;
      lines_r     <= lines_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_dv_r    <= out_dv_nxt;
    out_eol_r   <= out_eol_nxt;
    out_lines_r <= out_lines_nxt;
    out_lip_r   <= out_lip_nxt;
    out_ovr_r   <= out_ovr_nxt;
  end

  // Result channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_ovr_r, out_lip_r, out_lines_r, out_byte_r};
  assign out_tuser  = out_dv_r;
  assign out_tlast  = out_eol_r;

`ifndef ASSERT_OFF
  // A memory read always completes in the following cycle.
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ulrr_pkg::ST_READ) |=> (state_r == ulrr_pkg::ST_IDLE))
    else $error("read state lasted more than one cycle");

  // Every complete line holds at least its terminator in the ring.
  a_lines_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    lines_r <= fill_r)
    else $error("line count exceeds fill level");

  // The fill level never passes the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ulrr_pkg::FILL_W'(ulrr_pkg::RING_DEPTH))
    else $error("fill level beyond ring depth");

  // An end-of-line mark only comes with a popped byte.
  a_eol_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("end of line without popped byte");

  // A pop with no complete line is answered without a memory read and with no data.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == ulrr_pkg::REQ_POP) && !line_ready)
      |=> (out_tvalid && !out_tuser && (state_r == ulrr_pkg::ST_IDLE)))
    else $error("empty pop not answered");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the line-buffered serial receive ring.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MIXED_ITEMS = 500;

  // Expected content of one result transaction.
  typedef struct packed {
    logic [ulrr_pkg::BYTE_W-1:0]  data_byte;
    logic                         data_valid;
    logic                         end_of_line;
    logic [ulrr_pkg::LINES_W-1:0] lines_waiting;
    logic                         line_in_progress;
    logic                         overrun;
  } ring_result_t;

  // Tracks the ring contents and line count, and holds the results still owed by the block.
  class rx_line_tracker;
    logic [ulrr_pkg::BYTE_W-1:0] ring_bytes [ulrr_pkg::RING_DEPTH];
    int unsigned       wr_slot;
    int unsigned       rd_slot;
    int unsigned       fill_level;
    int unsigned       line_count;
    bit                partial_line;
    ring_result_t      pending_results [$];
    int                errors;
    int                results_checked;
    int                bytes_popped;
    int                lines_ended;
    int                bytes_dropped;
    int                empty_pops;

    // Apply one accepted request to the tracked state and queue its result.
    function void note_request(logic req, logic [ulrr_pkg::BYTE_W-1:0] rx);
      ring_result_t res;
      res = '0;
      if (req == ulrr_pkg::REQ_ARRIVE) begin
        if (fill_level >= ulrr_pkg::RING_DEPTH) begin
          // Full ring: the byte is dropped, a dropped line feed ends no line.
          res.overrun = 1'b1;
          bytes_dropped++;
        end else begin
          ring_bytes[wr_slot[ulrr_pkg::ADDR_W-1:0]] = rx;
          wr_slot = (wr_slot == ulrr_pkg::RING_DEPTH - 1) ? 0 : wr_slot + 1;
          fill_level++;
          partial_line = 1'b1;
          if (rx == ulrr_pkg::LINE_FEED) begin
            line_count++;
            partial_line = 1'b0;
          end
        end
      end else if (line_count > 0 && fill_level > 0) begin
        res.data_byte  = ring_bytes[rd_slot[ulrr_pkg::ADDR_W-1:0]];
        res.data_valid = 1'b1;
        rd_slot = (rd_slot == ulrr_pkg::RING_DEPTH - 1) ? 0 : rd_slot + 1;
        fill_level--;
        bytes_popped++;
        if (res.data_byte == ulrr_pkg::LINE_FEED) begin
          res.end_of_line = 1'b1;
          line_count--;
          lines_ended++;
        end
      end else begin
        // No complete line stored: the pop answers nothing.
        empty_pops++;
      end
      res.lines_waiting    = ulrr_pkg::LINES_W'(line_count);
      res.line_in_progress = partial_line;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    function void check_result(logic [ulrr_pkg::OUT_TDATA_W-1:0] tdata, logic tuser,
                               logic tlast);
      ring_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %b tlast %b",
               tdata, tuser, tlast);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      compare_field("data_byte", 32'(want.data_byte), 32'(tdata[7:0]));
      compare_field("data_valid", 32'(want.data_valid), 32'(tuser));
      compare_field("end_of_line", 32'(want.end_of_line), 32'(tlast));
      compare_field("lines_waiting", 32'(want.lines_waiting), 32'(tdata[18:8]));
      compare_field("line_in_progress", 32'(want.line_in_progress), 32'(tdata[19]));
      compare_field("overrun", 32'(want.overrun), 32'(tdata[20]));
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata   = '0;
  logic                             in_tuser   = ulrr_pkg::REQ_ARRIVE;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ulrr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tlast;

  rx_line_tracker tracker = new;
  int             items_sent;
  int             cycle_count;
  int             send_quiet;
  int             take_quiet;

  uart_line_receive_ring dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle cycles before a transaction, with occasional stretches of none at all.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Offer one request; valid stays high afterwards so back-to-back items need no gap.
  task automatic send_item(logic req, logic [7:0] rx);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(req, rx);
    items_sent++;
  endtask

  task automatic send_pop();
    send_item(ulrr_pkg::REQ_POP, 8'($urandom_range(0, 255)));
  endtask

  // One arriving byte that is never a line feed.
  task automatic send_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ulrr_pkg::LINE_FEED);
    send_item(ulrr_pkg::REQ_ARRIVE, b);
  endtask

  // A well-formed line: random bytes other than line feed, then the terminator.
  task automatic send_line(int len);
    repeat (len) send_text_byte();
    send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
  endtask

  // Result side: random stalls, every accepted result is checked.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_gap(take_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Stimulus and end of run.
  initial begin
    int r;
    logic [7:0] b;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, extreme bytes, pops on a partial line, an empty line.
    send_item(ulrr_pkg::REQ_POP, 8'hFF);
    send_item(ulrr_pkg::REQ_ARRIVE, 8'h00);
    send_item(ulrr_pkg::REQ_ARRIVE, 8'hFF);
    send_item(ulrr_pkg::REQ_POP, 8'h0A);
    send_item(ulrr_pkg::REQ_ARRIVE, 8'h0B);
    send_item(ulrr_pkg::REQ_ARRIVE, 8'h8A);
    send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
    send_item(ulrr_pkg::REQ_ARRIVE, 8'hF5);
    repeat (6) send_item(ulrr_pkg::REQ_POP, 8'h00);
    send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
    send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
    send_item(ulrr_pkg::REQ_POP, 8'hFF);
    send_item(ulrr_pkg::REQ_POP, 8'hFF);
    send_item(ulrr_pkg::REQ_POP, 8'hFF);
    send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
    send_item(ulrr_pkg::REQ_POP, 8'h55);
    send_item(ulrr_pkg::REQ_POP, 8'hAA);

    // Mixed traffic at low fill: mostly whole lines and pop bursts, some noise.
    while (items_sent < MIXED_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_line($urandom_range(0, 12));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 8)) send_pop();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(ulrr_pkg::REQ_ARRIVE, 8'($urandom_range(0, 255)));
        end
      end
    end

    // A few more whole lines, then one unterminated line up to a full ring.
    repeat (4) send_line($urandom_range(0, 12));
    while (tracker.fill_level < ulrr_pkg::RING_DEPTH) send_text_byte();
    // Push more bytes into the full ring so they are dropped, line feeds included.
    for (int i = 0; i < 24; i++) begin
      b = (i % 3 == 0) ? ulrr_pkg::LINE_FEED : 8'($urandom_range(0, 255));
      send_item(ulrr_pkg::REQ_ARRIVE, b);
    end
    // Hover at the full boundary: one slot freed, then two arrivals.
    repeat (10) begin
      send_pop();
      send_text_byte();
      send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
    end

    // Drain every complete line; the unterminated line stays behind.
    while (tracker.line_count > 0) send_pop();

    // Refill the freed slots with that same line: the ring locks up for good.
    while (tracker.fill_level < ulrr_pkg::RING_DEPTH) send_text_byte();
    repeat (3) begin
      send_item(ulrr_pkg::REQ_ARRIVE, ulrr_pkg::LINE_FEED);
      send_item(ulrr_pkg::REQ_ARRIVE, 8'($urandom_range(0, 255)));
      send_pop();
      send_pop();
    end
    in_tvalid <= 1'b0;

    while (tracker.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results in %0d cycles.",
             items_sent, tracker.results_checked, cycle_count);
    $display("Popped %0d bytes over %0d lines, %0d bytes dropped, %0d pops found no line.",
             tracker.bytes_popped, tracker.lines_ended, tracker.bytes_dropped,
             tracker.empty_pops);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
